// File: hdl/rfenc_pkg.sv
// Shared types and constants for the remote frame encoder.
// No dependencies; imported by rfenc_core and rf_remote_frame_encoder.
package rfenc_pkg;

	localparam int DEF_COMMAND_BYTES    = 3;
	localparam int DEF_PREAMBLE_SYMBOLS = 4;

	localparam int WORD_W  = 24;
	localparam int TICKS_W = 16;

	localparam logic [TICKS_W-1:0] CHIP_TICKS_RESET = 16'h0044;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	typedef struct packed {
		logic line;
		logic busy;
		logic done;
		logic rejected;
	} rfenc_res_t;

endpackage

// File: hdl/rfenc_core.sv
// Frame state, chip sequencing and tick counting for the remote frame encoder.
// Depends on rfenc_pkg; computes one result per processed transaction.
module rfenc_core #(
	parameter int COMMAND_BYTES    = rfenc_pkg::DEF_COMMAND_BYTES,
	parameter int PREAMBLE_SYMBOLS = rfenc_pkg::DEF_PREAMBLE_SYMBOLS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [rfenc_pkg::TICKS_W-1:0] cfg_wr_data,
	input  logic                         step,
	input  logic                         func,
	input  logic [rfenc_pkg::WORD_W-1:0]  command_word,
	output rfenc_pkg::rfenc_res_t        res
);
	import rfenc_pkg::*;

	localparam int CMD_BITS    = COMMAND_BYTES * 8;
	localparam int PRE_CHIPS   = PREAMBLE_SYMBOLS * 2;
	localparam int HEAD_CHIPS  = PRE_CHIPS + 3;
	localparam int FRAME_CHIPS = HEAD_CHIPS + CMD_BITS * 5;
	localparam int CHIP_W      = $clog2(FRAME_CHIPS + 1);

	localparam logic [2:0] PH_DATA_A = 3'd0;
	localparam logic [2:0] PH_DATA_B = 3'd1;
	localparam logic [2:0] PH_MARK_A = 3'd2;
	localparam logic [2:0] PH_MARK_B = 3'd3;
	localparam logic [2:0] PH_MARK_C = 3'd4;

	logic [TICKS_W-1:0]  chip_ticks_q;
	logic [CMD_BITS-1:0] shift_q, shift_d;
	logic [CHIP_W-1:0]   chip_q, chip_d;
	logic [2:0]          phase_q, phase_d;
	logic [TICKS_W-1:0]  tick_q, tick_d;
	logic                line_q, line_d;
	logic                sending_q, sending_d;

	logic [CMD_BITS-1:0] cmd_load;
	logic [TICKS_W-1:0]  tick_inc;
	logic [TICKS_W-1:0]  limit;
	logic                chip_end;
	logic [CHIP_W-1:0]   chip_inc;
	logic                last_chip;
	logic [CMD_BITS-1:0] shift_n;
	logic [2:0]          phase_n;
	logic                level_n;
	logic                done;
	logic                rejected;

	if (CMD_BITS > WORD_W) begin : g_wide
		assign cmd_load = {{(CMD_BITS - WORD_W){1'b0}}, command_word};
	end else if (CMD_BITS == WORD_W) begin : g_same
		assign cmd_load = command_word;
	end else begin : g_narrow
		assign cmd_load = command_word[CMD_BITS-1:0];
	end

	always_comb begin
		tick_inc  = tick_q + TICKS_W'(1);
		limit     = (chip_ticks_q == '0) ? TICKS_W'(1) : chip_ticks_q;
		chip_end  = (tick_inc >= limit) || (tick_inc == '0);
		chip_inc  = chip_q + CHIP_W'(1);
		last_chip = chip_inc >= CHIP_W'(FRAME_CHIPS);

		shift_n = shift_q;
		phase_n = PH_DATA_A;
		if (chip_inc > CHIP_W'(HEAD_CHIPS)) begin
			if (phase_q == PH_MARK_C) begin
				phase_n = PH_DATA_A;
				shift_n = shift_q << 1;
			end else begin
				phase_n = phase_q + 3'd1;
			end
		end

		if (chip_inc < CHIP_W'(PRE_CHIPS)) begin
			level_n = chip_inc[0];
		end else if (chip_inc < CHIP_W'(HEAD_CHIPS)) begin
			level_n = (chip_inc == CHIP_W'(PRE_CHIPS + 1));
		end else begin
			unique case (phase_n)
				PH_DATA_A:            level_n = ~shift_n[CMD_BITS-1];
				PH_DATA_B:            level_n = shift_n[CMD_BITS-1];
				PH_MARK_B:            level_n = 1'b1;
				PH_MARK_A, PH_MARK_C: level_n = 1'b0;
				default:              level_n = 1'b0;
			endcase
		end
	end

	always_comb begin
		shift_d   = shift_q;
		chip_d    = chip_q;
		phase_d   = phase_q;
		tick_d    = tick_q;
		line_d    = line_q;
		sending_d = sending_q;
		done      = 1'b0;
		rejected  = 1'b0;
		if (func == FUNC_START) begin
			if (sending_q) begin
				rejected = 1'b1;
			end else begin
				shift_d   = cmd_load;
				chip_d    = '0;
				phase_d   = PH_DATA_A;
				tick_d    = '0;
				sending_d = 1'b1;
				line_d    = 1'b0;
			end
		end else if (sending_q) begin
			tick_d = tick_inc;
			if (chip_end) begin
				tick_d = '0;
				if (last_chip) begin
					chip_d    = '0;
					phase_d   = PH_DATA_A;
					sending_d = 1'b0;
					line_d    = 1'b0;
					done      = 1'b1;
				end else begin
					chip_d  = chip_inc;
					phase_d = phase_n;
					shift_d = shift_n;
					line_d  = level_n;
				end
			end
		end
	end

	assign res = '{line: line_d, busy: sending_d, done: done, rejected: rejected};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_ticks_q <= CHIP_TICKS_RESET;
		end else if (cfg_wr_en) begin
			chip_ticks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= '0;
			chip_q    <= '0;
			phase_q   <= PH_DATA_A;
			tick_q    <= '0;
			line_q    <= 1'b0;
			sending_q <= 1'b0;
		end else if (step) begin
			shift_q   <= shift_d;
			chip_q    <= chip_d;
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			line_q    <= line_d;
			sending_q <= sending_d;
		end
	end

	a_idle_line_low: assert property (@(posedge clk) disable iff (!arst_n)
		!sending_q |-> !line_q)
		else $error("line high while idle");

	a_chip_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		chip_q < CHIP_W'(FRAME_CHIPS))
		else $error("chip index beyond frame");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_MARK_C)
		else $error("symbol phase out of range");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && func == FUNC_START && !sending_q |=>
			sending_q && chip_q == '0 && tick_q == '0 && !line_q)
		else $error("start from idle did not open a frame");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done |=> !sending_q && !line_q && chip_q == '0)
		else $error("frame end left state active");

endmodule

// File: hdl/rf_remote_frame_encoder.sv
// Remote frame encoder top level: input register, encoder core, result register.
// Depends on rfenc_pkg and rfenc_core.
//
// Usage: each input transaction is either a timer tick (func = 0) or a start
// (func = 1) carrying the command word. A start while idle latches the word
// and begins a frame of preamble, marker and Manchester data chips; a start
// during a frame is dropped and flagged on start_rejected. Each tick advances
// the hold counter, and after chip_ticks ticks the line moves to the next chip.
// Every input transaction yields exactly one result transaction with the line
// level, busy flag, frame-done flag and rejection flag after the update.
// A result passes through the input register, then the result register, which
// loads when the core steps. Throughput: one transaction per cycle while the
// receiver does not stall; the core updates its state combinationally.
// The config write chip_ticks is taken at once and applies from the next tick.
// Reset clears the frame state, sets the core line level low and loads chip_ticks = 68.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops until the result is taken.
module rf_remote_frame_encoder #(
	parameter int COMMAND_BYTES    = rfenc_pkg::DEF_COMMAND_BYTES,
	parameter int PREAMBLE_SYMBOLS = rfenc_pkg::DEF_PREAMBLE_SYMBOLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [rfenc_pkg::TICKS_W-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [rfenc_pkg::WORD_W-1:0]  command_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          line_out,
	output logic                          busy_res,
	output logic                          frame_done,
	output logic                          start_rejected
);
	import rfenc_pkg::*;

	logic               valid_s1;
	logic               func_s1;
	logic [WORD_W-1:0]  word_s1;
	logic               advance;
	logic               out_valid_q;
	rfenc_res_t         res;
	rfenc_res_t         res_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1 <= func;
			word_s1 <= command_word;
		end
	end

	rfenc_core #(
		.COMMAND_BYTES   (COMMAND_BYTES),
		.PREAMBLE_SYMBOLS(PREAMBLE_SYMBOLS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance),
		.func        (func_s1),
		.command_word(word_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign line_out       = res_q.line;
	assign busy_res       = res_q.busy;
	assign frame_done     = res_q.done;
	assign start_rejected = res_q.rejected;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done |-> !res_q.busy && !res_q.line && !res_q.rejected)
		else $error("frame end reported with line or busy active");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.rejected |-> res_q.busy && !res_q.done)
		else $error("rejection reported while idle");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(res_q))
		else $error("stalled result changed");

endmodule
